### design/ascii_command_frame_receiver_assert.svh
// ---------------------------------------------------------------------------
// ascii_command_frame_receiver_assert.svh
// assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASCII_COMMAND_FRAME_RECEIVER_ASSERT_SVH
`define ASCII_COMMAND_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define ACFR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("acfr assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define ACFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("acfr assertion failed");

`endif

### design/acfr_pkg.sv
// ---------------------------------------------------------------------------
// acfr_pkg
// constants, register codes, types and digit arithmetic of the frame receiver
// ---------------------------------------------------------------------------
package acfr_pkg;

  // buffer geometry
  localparam int FRAME_BYTES = 16;
  localparam int POS_W       = $clog2(FRAME_BYTES);
  localparam int CNT_W       = $clog2(FRAME_BYTES + 1);
  localparam int OFS_W       = (CNT_W > 5) ? CNT_W : 5;
  localparam int ADDR_W      = POS_W + 1;
  localparam int READS       = 7;

  // read slots of the decoder
  localparam int SLOT_MOVE  = 0;
  localparam int SLOT_ANGLE = 1;
  localparam int SLOT_SPEED = 4;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_START_MARKER   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_MARKER    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_CODE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_POSITION  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_POSITION = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_POSITION = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LIFETIME_MAX   = 3'd6;

  // register reset values
  localparam logic [7:0] START_MARKER_RESET   = 8'd35;
  localparam logic [7:0] STOP_MARKER_RESET    = 8'd36;
  localparam logic [7:0] MOVE_CODE_RESET      = 8'd49;
  localparam logic [3:0] MOVE_POSITION_RESET  = 4'd1;
  localparam logic [3:0] ANGLE_POSITION_RESET = 4'd2;
  localparam logic [3:0] SPEED_POSITION_RESET = 4'd5;
  localparam logic [7:0] LIFETIME_MAX_RESET   = 8'd10;
  localparam logic [7:0] LIFETIME_RESET       = 8'd10;

  // item codes
  localparam logic OP_BYTE      = 1'b0;
  localparam logic OP_TICK      = 1'b1;
  localparam logic CAUSE_DECODE = 1'b0;
  localparam logic CAUSE_EXPIRY = 1'b1;

  // link owner codes
  localparam logic [1:0] OWNER_NONE   = 2'd0;
  localparam logic [1:0] OWNER_FIRST  = 2'd1;
  localparam logic [1:0] OWNER_SECOND = 2'd2;

  // ascii digit arithmetic
  localparam logic [15:0] ASCII_ZERO      = 16'd48;
  localparam logic [15:0] WEIGHT_HUNDREDS = 16'd100;
  localparam logic [15:0] WEIGHT_TENS     = 16'd10;

  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] stop_marker;
    logic [7:0] move_code;
    logic [3:0] move_position;
    logic [3:0] angle_position;
    logic [3:0] speed_position;
    logic [7:0] lifetime_max;
  } cfg_t;

  // store write from the control stage: req while the item sits, commit as it leaves
  typedef struct packed {
    logic              req;
    logic              commit;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } store_wr_t;

  // three ascii digits to a value modulo 2^16
  function automatic logic [15:0] digits_value(input logic [7:0] d0, input logic [7:0] d1,
                                               input logic [7:0] d2);
    logic [15:0] v0;
    logic [15:0] v1;
    logic [15:0] v2;
    v0 = {8'd0, d0} - ASCII_ZERO;
    v1 = {8'd0, d1} - ASCII_ZERO;
    v2 = {8'd0, d2} - ASCII_ZERO;
    return 16'(v0 * WEIGHT_HUNDREDS) + 16'(v1 * WEIGHT_TENS) + v2;
  endfunction

endpackage

### design/acfr_ram.sv
// ---------------------------------------------------------------------------
// acfr_ram
// simple dual port ram, one write and one registered read, old data on collision
// ---------------------------------------------------------------------------
module acfr_ram #(
  parameter int DATA_W = 8,
  parameter int ADDR_W = 5
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/acfr_cfg_regs.sv
// ---------------------------------------------------------------------------
// acfr_cfg_regs
// configuration register file written through the cfg channel
// ---------------------------------------------------------------------------
module acfr_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [acfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  output acfr_pkg::cfg_t                 cfg
);

  assign cfg_ready = 1'b1;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_marker   <= acfr_pkg::START_MARKER_RESET;
      cfg.stop_marker    <= acfr_pkg::STOP_MARKER_RESET;
      cfg.move_code      <= acfr_pkg::MOVE_CODE_RESET;
      cfg.move_position  <= acfr_pkg::MOVE_POSITION_RESET;
      cfg.angle_position <= acfr_pkg::ANGLE_POSITION_RESET;
      cfg.speed_position <= acfr_pkg::SPEED_POSITION_RESET;
      cfg.lifetime_max   <= acfr_pkg::LIFETIME_MAX_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        acfr_pkg::REG_START_MARKER:   cfg.start_marker   <= cfg_data;
        acfr_pkg::REG_STOP_MARKER:    cfg.stop_marker    <= cfg_data;
        acfr_pkg::REG_MOVE_CODE:      cfg.move_code      <= cfg_data;
        acfr_pkg::REG_MOVE_POSITION:  cfg.move_position  <= cfg_data[3:0];
        acfr_pkg::REG_ANGLE_POSITION: cfg.angle_position <= cfg_data[3:0];
        acfr_pkg::REG_SPEED_POSITION: cfg.speed_position <= cfg_data[3:0];
        acfr_pkg::REG_LIFETIME_MAX:   cfg.lifetime_max   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

### design/acfr_frame_store.sv
// ---------------------------------------------------------------------------
// acfr_frame_store
// two channel byte buffers, read at the seven decode positions on accept
// ---------------------------------------------------------------------------
module acfr_frame_store (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                rd_en,
  input  logic                                rd_ch,
  input  acfr_pkg::cfg_t                      cfg,
  input  acfr_pkg::store_wr_t                 wr,
  output logic [acfr_pkg::READS-1:0][7:0]     rd_bytes
);

  localparam int READS  = acfr_pkg::READS;
  localparam int ADDR_W = acfr_pkg::ADDR_W;
  localparam int POS_W  = acfr_pkg::POS_W;
  localparam int OFS_W  = acfr_pkg::OFS_W;

  logic [3:0]              slot_base [READS];
  logic [1:0]              slot_step [READS];
  logic [OFS_W-1:0]        slot_ofs  [READS];
  logic [READS-1:0]        slot_in_range;
  logic [ADDR_W-1:0]       raddr     [READS];

  logic [2**ADDR_W-1:0]    written;
  logic [ADDR_W-1:0]       addr_q    [READS];
  logic [READS-1:0]        range_q;
  logic [READS-1:0]        written_q;
  logic [READS-1:0]        fwd_q;
  logic [7:0]              fwd_data_q;
  logic [7:0]              ram_q     [READS];

  // read positions: move byte, then three angle and three speed digits
  always_comb begin
    for (int k = 0; k < READS; k++) begin
      if (k < acfr_pkg::SLOT_ANGLE) begin
        slot_base[k] = cfg.move_position;
        slot_step[k] = 2'(k - acfr_pkg::SLOT_MOVE);
      end else if (k < acfr_pkg::SLOT_SPEED) begin
        slot_base[k] = cfg.angle_position;
        slot_step[k] = 2'(k - acfr_pkg::SLOT_ANGLE);
      end else begin
        slot_base[k] = cfg.speed_position;
        slot_step[k] = 2'(k - acfr_pkg::SLOT_SPEED);
      end
      slot_ofs[k]      = OFS_W'(slot_base[k]) + OFS_W'(slot_step[k]);
      slot_in_range[k] = slot_ofs[k] < OFS_W'(acfr_pkg::FRAME_BYTES);
      raddr[k]         = {rd_ch, slot_ofs[k][POS_W-1:0]};
    end
  end

  // written marks, so never-written entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr.commit) begin
      written[wr.addr] <= 1'b1;
    end
  end

  // per-slot read side data, with the byte written on the same edge forwarded
  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data_q <= wr.data;
      for (int k = 0; k < READS; k++) begin
        addr_q[k]    <= raddr[k];
        range_q[k]   <= slot_in_range[k];
        written_q[k] <= written[raddr[k]];
        fwd_q[k]     <= wr.commit && (wr.addr == raddr[k]);
      end
    end
  end

  // one ram copy per read slot, all written alike
  for (genvar g = 0; g < READS; g++) begin : g_copy
    acfr_ram #(
      .DATA_W(8),
      .ADDR_W(ADDR_W)
    ) u_ram (
      .clk  (clk),
      .we   (wr.commit),
      .waddr(wr.addr),
      .wdata(wr.data),
      .re   (rd_en),
      .raddr(raddr[g]),
      .rdata(ram_q[g])
    );
  end

  // read data for the item in the control stage, its own byte included
  always_comb begin
    for (int k = 0; k < READS; k++) begin
      if (!range_q[k]) begin
        rd_bytes[k] = 8'd0;
      end else if (wr.req && (wr.addr == addr_q[k])) begin
        rd_bytes[k] = wr.data;
      end else if (fwd_q[k]) begin
        rd_bytes[k] = fwd_data_q;
      end else if (written_q[k]) begin
        rd_bytes[k] = ram_q[k];
      end else begin
        rd_bytes[k] = 8'd0;
      end
    end
  end

endmodule

### design/acfr_ctrl.sv
// ---------------------------------------------------------------------------
// acfr_ctrl
// input register, frame and link state, decode and result register
// ---------------------------------------------------------------------------
module acfr_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,
  input  logic [1:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [39:0]                     m_tdata,
  output logic [0:0]                      m_tuser,
  input  acfr_pkg::cfg_t                  cfg,
  input  logic [acfr_pkg::READS-1:0][7:0] rd_bytes,
  output acfr_pkg::store_wr_t             wr
);

  localparam int CNT_W = acfr_pkg::CNT_W;
  localparam int POS_W = acfr_pkg::POS_W;

  // input register
  logic       a_valid;
  logic       a_op;
  logic       a_ch;
  logic [7:0] a_byte;

  // frame and link state
  logic [CNT_W-1:0] write_position;
  logic [CNT_W-1:0] write_position_next;
  logic             frame_open;
  logic             frame_open_next;
  logic [1:0]       owner;
  logic [1:0]       owner_next;
  logic [7:0]       lifetime;
  logic [7:0]       lifetime_next;
  logic             move_held;
  logic             move_held_next;
  logic [15:0]      angle_held;
  logic [15:0]      angle_held_next;
  logic [15:0]      speed_held;
  logic [15:0]      speed_held_next;

  // result register
  logic        out_valid;
  logic        out_cause;
  logic        out_move;
  logic [15:0] out_angle;
  logic [15:0] out_speed;
  logic [1:0]  out_owner;

  logic is_start;
  logic in_frame;
  logic is_stop;
  logic expired;
  logic a_result;
  logic a_advance;
  logic do_store;

  // handshake: the input stage leaves unless a result would hit a full, stalled output
  assign a_advance = a_valid && (!a_result || !out_valid || m_tready);
  assign s_tready  = !a_valid || a_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tready) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      a_op   <= s_tuser[0];
      a_ch   <= s_tuser[1];
      a_byte <= s_tdata;
    end
  end

  // classify the item in the input stage
  always_comb begin
    is_start = (a_op == acfr_pkg::OP_BYTE) && (a_byte == cfg.start_marker);
    in_frame = (a_op == acfr_pkg::OP_BYTE) && !is_start && frame_open;
    is_stop  = in_frame && (a_byte == cfg.stop_marker);
    expired  = (a_op == acfr_pkg::OP_TICK) && (lifetime == 8'd0);
    a_result = is_stop || expired;
  end

  // next state of position, frame, link and held values
  always_comb begin
    write_position_next = write_position;
    frame_open_next     = frame_open;
    owner_next          = owner;
    lifetime_next       = lifetime;
    move_held_next      = move_held;
    angle_held_next     = angle_held;
    speed_held_next     = speed_held;

    if (is_start) begin
      write_position_next = '0;
      frame_open_next     = 1'b1;
    end else if (in_frame) begin
      if (write_position < CNT_W'(acfr_pkg::FRAME_BYTES)) begin
        write_position_next = write_position + CNT_W'(1);
      end
    end

    if (is_stop) begin
      frame_open_next = 1'b0;
      lifetime_next   = cfg.lifetime_max;
      if (!a_ch && (owner != acfr_pkg::OWNER_SECOND)) begin
        owner_next = acfr_pkg::OWNER_FIRST;
      end else if (a_ch && (owner != acfr_pkg::OWNER_FIRST)) begin
        owner_next = acfr_pkg::OWNER_SECOND;
      end
      move_held_next  = rd_bytes[acfr_pkg::SLOT_MOVE] == cfg.move_code;
      angle_held_next = acfr_pkg::digits_value(rd_bytes[acfr_pkg::SLOT_ANGLE],
                                               rd_bytes[acfr_pkg::SLOT_ANGLE + 1],
                                               rd_bytes[acfr_pkg::SLOT_ANGLE + 2]);
      speed_held_next = acfr_pkg::digits_value(rd_bytes[acfr_pkg::SLOT_SPEED],
                                               rd_bytes[acfr_pkg::SLOT_SPEED + 1],
                                               rd_bytes[acfr_pkg::SLOT_SPEED + 2]);
    end else if (expired) begin
      owner_next     = acfr_pkg::OWNER_NONE;
      move_held_next = 1'b0;
    end else if (a_op == acfr_pkg::OP_TICK) begin
      lifetime_next = lifetime - 8'd1;
    end
  end

  // store write of the byte at its new position
  always_comb begin
    do_store  = (is_start || in_frame)
                && (write_position_next < CNT_W'(acfr_pkg::FRAME_BYTES));
    wr.req    = a_valid && do_store;
    wr.commit = a_valid && do_store && a_advance;
    wr.addr   = {a_ch, write_position_next[POS_W-1:0]};
    wr.data   = a_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_position <= '0;
      frame_open     <= 1'b0;
      owner          <= acfr_pkg::OWNER_NONE;
      lifetime       <= acfr_pkg::LIFETIME_RESET;
      move_held      <= 1'b0;
      angle_held     <= 16'd0;
      speed_held     <= 16'd0;
    end else if (a_advance) begin
      write_position <= write_position_next;
      frame_open     <= frame_open_next;
      owner          <= owner_next;
      lifetime       <= lifetime_next;
      move_held      <= move_held_next;
      angle_held     <= angle_held_next;
      speed_held     <= speed_held_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_advance && a_result) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_advance && a_result) begin
      out_cause <= expired ? acfr_pkg::CAUSE_EXPIRY : acfr_pkg::CAUSE_DECODE;
      out_move  <= move_held_next;
      out_angle <= angle_held_next;
      out_speed <= speed_held_next;
      out_owner <= owner_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_owner, out_speed, out_angle, out_move};
  assign m_tuser  = out_cause;

endmodule

### design/ascii_command_frame_receiver.sv
// ---------------------------------------------------------------------------
// ascii_command_frame_receiver
// two-link ascii command frame receiver with time-to-live link supervision
//
//   channel  | direction | words
//   ---------+-----------+-----------------------------------------------
//   s_*      | in        | received byte or send tick, one per word
//   m_*      | out       | decoded frame or link-lost report
//   cfg_*    | in        | register index and value, always ready
//
// one word a cycle sustained while no result stalls; a result passes the input and result registers
// the rate is set by the single decode stage between input and result register
// the decoder reads seven buffer positions through seven ram copies
// reset clears state at once; never-written buffer entries read as zero
// while a result stalls, words without a result still pass; the next word
// with a result is held in the input register and s_tready drops
// ---------------------------------------------------------------------------
module ascii_command_frame_receiver (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [7:0]                     s_tdata,   // rx_byte
  input  logic [1:0]                     s_tuser,   // operation, channel
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [39:0]                    m_tdata,   // move_enable, angle_value,
                                                    // speed_value, link_owner
  output logic [0:0]                     m_tuser,   // cause
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [acfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data
);

  acfr_pkg::cfg_t                  cfg;
  acfr_pkg::store_wr_t             wr;
  logic [acfr_pkg::READS-1:0][7:0] rd_bytes;

  // configuration registers
  acfr_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  // frame buffers, read as a word is accepted
  acfr_frame_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (s_tvalid && s_tready),
    .rd_ch   (s_tuser[1]),
    .cfg     (cfg),
    .wr      (wr),
    .rd_bytes(rd_bytes)
  );

  // control and decode
  acfr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .cfg     (cfg),
    .rd_bytes(rd_bytes),
    .wr      (wr)
  );

endmodule

### design/acfr_checker.sv
// ---------------------------------------------------------------------------
// acfr_checker
// port level checks of the frame receiver, bound to the top level
// ---------------------------------------------------------------------------
`include "ascii_command_frame_receiver_assert.svh"

module acfr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic [0:0]  m_tuser
);

  logic       in_accept;
  logic       expiry_shown;
  logic       decode_shown;
  logic       move_shown;
  logic [1:0] owner_shown;

  // result fields as seen on the port
  assign in_accept    = s_tvalid && s_tready;
  assign expiry_shown = m_tvalid && (m_tuser[0] == acfr_pkg::CAUSE_EXPIRY);
  assign decode_shown = m_tvalid && (m_tuser[0] == acfr_pkg::CAUSE_DECODE);
  assign move_shown   = m_tdata[0];
  assign owner_shown  = m_tdata[34:33];

  // a link-lost report shows no owner and no move
  `ACFR_ASSERT_IMP(a_expiry_clears, expiry_shown, (owner_shown == acfr_pkg::OWNER_NONE) && !move_shown)

  // a decoded frame always leaves some link connected
  `ACFR_ASSERT_IMP(a_decode_owned, decode_shown, owner_shown != acfr_pkg::OWNER_NONE)

  // a fresh result follows an accepted word, through the input and result registers
  `ACFR_ASSERT_IMP(a_result_latency, $rose(m_tvalid), $past(in_accept, 2))

  // a stalled result holds
  `ACFR_ASSERT_NEXT(a_result_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

endmodule

bind ascii_command_frame_receiver acfr_checker u_checker (.*);

### bench/tb_ascii_command_frame_receiver.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_ascii_command_frame_receiver
// self-checking bench for the two-link ascii command frame receiver
//
// byte and tick words go in through the s_* stream. A behavioural copy of
// the receiver (frame buffers, shared write position, link owner,
// time-to-live) works out every decode and link-lost report. Each word on
// m_* is checked field by field against the oldest pending report.
// Directed tests come first, then random frames, ticks and line noise under
// three idling profiles, one long receiver hold-off and several register
// settings.
// ---------------------------------------------------------------------------
module tb_ascii_command_frame_receiver;

  localparam logic [7:0] CHR_START = 8'h23;  // '#'
  localparam logic [7:0] CHR_STOP  = 8'h24;  // '$'
  localparam logic       LINK_A    = 1'b0;
  localparam logic       LINK_B    = 1'b1;

  typedef struct packed {
    logic        cause;
    logic        move_enable;
    logic [15:0] angle_value;
    logic [15:0] speed_value;
    logic [1:0]  link_owner;
  } link_report_t;

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           s_tvalid  = 1'b0;
  logic                           s_tready;
  logic [7:0]                     s_tdata   = 8'd0;   // rx_byte
  logic [1:0]                     s_tuser   = 2'd0;   // operation, channel
  logic                           m_tvalid;
  logic                           m_tready  = 1'b0;
  logic [39:0]                    m_tdata;            // move_enable, angle_value,
                                                      // speed_value, link_owner
  logic [0:0]                     m_tuser;            // cause
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [acfr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]                     cfg_data  = 8'd0;

  // bench control
  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int          hold_cycles   = 0;
  int unsigned words_sent    = 0;
  int unsigned errors        = 0;

  // behavioural copy of the receiver
  logic [7:0]   start_mk   = acfr_pkg::START_MARKER_RESET;
  logic [7:0]   stop_mk    = acfr_pkg::STOP_MARKER_RESET;
  logic [7:0]   move_cd    = acfr_pkg::MOVE_CODE_RESET;
  logic [3:0]   move_pos   = acfr_pkg::MOVE_POSITION_RESET;
  logic [3:0]   angle_pos  = acfr_pkg::ANGLE_POSITION_RESET;
  logic [3:0]   speed_pos  = acfr_pkg::SPEED_POSITION_RESET;
  logic [7:0]   life_max   = acfr_pkg::LIFETIME_MAX_RESET;
  int unsigned  wr_pos     = 0;
  bit           frame_live = 1'b0;
  logic [7:0]   link_buf [2][acfr_pkg::FRAME_BYTES];
  logic [1:0]   holder     = acfr_pkg::OWNER_NONE;
  logic [7:0]   ttl        = acfr_pkg::LIFETIME_RESET;
  logic         move_q     = 1'b0;
  logic [15:0]  angle_q    = 16'd0;
  logic [15:0]  speed_q    = 16'd0;
  link_report_t pending_reports [$];
  link_report_t got, want;

  ascii_command_frame_receiver i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  always #4 clk = ~clk;

  // receiver side: random stalls, or a counted hold-off when asked
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      m_tready    <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("ascii_command_frame_receiver: mismatch");
    $finish;
  end

  task automatic report_error(input string what);
    $display("error at %0t: %s", $realtime, what);
    errors++;
  endtask

  // buffer read, positions past the end read as zero
  function automatic logic [7:0] buf_byte(input logic ch, input int unsigned pos);
    if (pos >= acfr_pkg::FRAME_BYTES) return 8'd0;
    return link_buf[ch][pos];
  endfunction

  // three ascii digits, weighted, wrapped to 16 bits
  function automatic logic [15:0] digit_value(input logic ch, input int unsigned pos);
    logic [15:0] h;
    logic [15:0] t;
    logic [15:0] u;
    h = {8'd0, buf_byte(ch, pos)} - acfr_pkg::ASCII_ZERO;
    t = {8'd0, buf_byte(ch, pos + 1)} - acfr_pkg::ASCII_ZERO;
    u = {8'd0, buf_byte(ch, pos + 2)} - acfr_pkg::ASCII_ZERO;
    return 16'(h * acfr_pkg::WEIGHT_HUNDREDS) + 16'(t * acfr_pkg::WEIGHT_TENS) + u;
  endfunction

  // advance the copy by one accepted word, queue any report it causes
  function automatic void predict_word(input logic op, input logic ch, input logic [7:0] data);
    // send tick: count down, or drop the link once expired
    if (op == acfr_pkg::OP_TICK) begin
      if (ttl == 8'd0) begin
        holder = acfr_pkg::OWNER_NONE;
        move_q = 1'b0;
        pending_reports.push_back(link_report_t'{acfr_pkg::CAUSE_EXPIRY, move_q,
                                                 angle_q, speed_q, holder});
      end else begin
        ttl = ttl - 8'd1;
      end
      return;
    end
    // start byte always (re)opens a frame at position zero
    if (data == start_mk) begin
      wr_pos     = 0;
      frame_live = 1'b1;
      link_buf[ch][0] = data;
      return;
    end
    if (!frame_live) return;
    if (wr_pos < acfr_pkg::FRAME_BYTES) wr_pos++;
    if (wr_pos < acfr_pkg::FRAME_BYTES) link_buf[ch][wr_pos] = data;
    if (data != stop_mk) return;
    // stop byte: close, claim and decode
    frame_live = 1'b0;
    ttl        = life_max;
    if (ch == LINK_A && holder != acfr_pkg::OWNER_SECOND) holder = acfr_pkg::OWNER_FIRST;
    else if (ch == LINK_B && holder != acfr_pkg::OWNER_FIRST) holder = acfr_pkg::OWNER_SECOND;
    move_q  = (buf_byte(ch, move_pos) == move_cd);
    angle_q = digit_value(ch, angle_pos);
    speed_q = digit_value(ch, speed_pos);
    pending_reports.push_back(link_report_t'{acfr_pkg::CAUSE_DECODE, move_q,
                                             angle_q, speed_q, holder});
  endfunction

  function automatic void apply_reg(input logic [acfr_pkg::CFG_IDX_W-1:0] idx,
                                    input logic [7:0] val);
    case (idx)
      acfr_pkg::REG_START_MARKER:   start_mk  = val;
      acfr_pkg::REG_STOP_MARKER:    stop_mk   = val;
      acfr_pkg::REG_MOVE_CODE:      move_cd   = val;
      acfr_pkg::REG_MOVE_POSITION:  move_pos  = val[3:0];
      acfr_pkg::REG_ANGLE_POSITION: angle_pos = val[3:0];
      acfr_pkg::REG_SPEED_POSITION: speed_pos = val[3:0];
      acfr_pkg::REG_LIFETIME_MAX:   life_max  = val;
      default: ;
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tuser[0], m_tdata[0], m_tdata[16:1], m_tdata[32:17], m_tdata[34:33]};
      if (pending_reports.size() == 0) begin
        report_error("result word with nothing pending");
      end else begin
        want = pending_reports.pop_front();
        if (got.cause != want.cause)
          report_error($sformatf("cause %0d, want %0d", got.cause, want.cause));
        if (got.move_enable != want.move_enable)
          report_error($sformatf("move_enable %0d, want %0d",
                                 got.move_enable, want.move_enable));
        if (got.angle_value != want.angle_value)
          report_error($sformatf("angle_value %0d, want %0d",
                                 got.angle_value, want.angle_value));
        if (got.speed_value != want.speed_value)
          report_error($sformatf("speed_value %0d, want %0d",
                                 got.speed_value, want.speed_value));
        if (got.link_owner != want.link_owner)
          report_error($sformatf("link_owner %0d, want %0d",
                                 got.link_owner, want.link_owner));
      end
    end
  end

  // one input word, with random idle cycles ahead of it
  task automatic send_word(input logic op, input logic ch, input logic [7:0] data);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= {ch, op};
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
    predict_word(op, ch, data);
    words_sent++;
  endtask

  // wait for every report, then let words without a report settle
  task automatic wait_quiet();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [acfr_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_settings(input logic [7:0] start_b, input logic [7:0] stop_b,
                               input logic [7:0] code, input logic [3:0] mpos,
                               input logic [3:0] apos, input logic [3:0] spos,
                               input logic [7:0] life);
    wait_quiet();
    write_reg(acfr_pkg::REG_START_MARKER,   start_b);
    write_reg(acfr_pkg::REG_STOP_MARKER,    stop_b);
    write_reg(acfr_pkg::REG_MOVE_CODE,      code);
    write_reg(acfr_pkg::REG_MOVE_POSITION,  {4'd0, mpos});
    write_reg(acfr_pkg::REG_ANGLE_POSITION, {4'd0, apos});
    write_reg(acfr_pkg::REG_SPEED_POSITION, {4'd0, spos});
    write_reg(acfr_pkg::REG_LIFETIME_MAX,   life);
  endtask

  task automatic send_text(input logic ch, input string text);
    foreach (text[i]) send_word(acfr_pkg::OP_BYTE, ch, text[i]);
  endtask

  // one frame with random content; sometimes long, sometimes mixed links
  task automatic send_frame();
    logic        ch;
    int unsigned len;
    logic [7:0]  b;
    ch  = 1'($urandom_range(1));
    len = ($urandom_range(7) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 10);
    send_word(acfr_pkg::OP_BYTE, ch, start_mk);
    for (int unsigned i = 1; i <= len; i++) begin
      if (i == move_pos && $urandom_range(1)) b = move_cd;
      else if ($urandom_range(3) != 0)        b = 8'(8'h30 + $urandom_range(9));
      else                                    b = 8'($urandom_range(255));
      send_word(acfr_pkg::OP_BYTE, ($urandom_range(9) == 0) ? ~ch : ch, b);
    end
    send_word(acfr_pkg::OP_BYTE, ($urandom_range(7) == 0) ? ~ch : ch, stop_mk);
  endtask

  // random register setting, markers kept apart
  task automatic randomise_settings();
    logic [7:0] start_b;
    logic [7:0] stop_b;
    logic [7:0] life;
    if ($urandom_range(1)) begin
      start_b = CHR_START;
      stop_b  = CHR_STOP;
    end else begin
      start_b = 8'($urandom_range(255));
      do stop_b = 8'($urandom_range(255)); while (stop_b == start_b);
    end
    life = ($urandom_range(3) == 0) ? 8'd255 : 8'($urandom_range(6));
    load_settings(start_b, stop_b,
                  $urandom_range(1) ? 8'($urandom_range(48, 57)) : 8'($urandom_range(255)),
                  4'($urandom_range(15)), 4'($urandom_range(13)), 4'($urandom_range(13)),
                  life);
  endtask

  // plain frames at reset settings, noise outside a frame, extreme bytes
  task automatic test_basic_frames();
    send_word(acfr_pkg::OP_BYTE, LINK_A, "A");
    send_text(LINK_A, "#1123456$");
    send_word(acfr_pkg::OP_TICK, LINK_B, 8'hFF);
    send_word(acfr_pkg::OP_BYTE, LINK_B, CHR_START);
    send_word(acfr_pkg::OP_BYTE, LINK_B, 8'hFF);
    send_word(acfr_pkg::OP_BYTE, LINK_B, 8'h00);
    send_word(acfr_pkg::OP_BYTE, LINK_B, CHR_STOP);
  endtask

  // register extremes, zero lifetime, repeated expiry, claim after loss
  task automatic test_register_extremes();
    load_settings(8'h00, 8'hFF, 8'hFF, 4'd15, 4'd13, 4'd0, 8'd0);
    send_word(acfr_pkg::OP_BYTE, LINK_B, 8'h00);
    send_word(acfr_pkg::OP_BYTE, LINK_B, 8'hFF);
    send_word(acfr_pkg::OP_TICK, LINK_A, 8'h00);
    send_word(acfr_pkg::OP_TICK, LINK_B, 8'hFF);
    send_word(acfr_pkg::OP_BYTE, LINK_B, 8'h00);
    send_word(acfr_pkg::OP_BYTE, LINK_B, 8'hFF);
    send_word(acfr_pkg::OP_TICK, LINK_A, 8'h5A);
  endtask

  // start and stop marker equal: the byte only ever restarts
  task automatic test_equal_markers();
    load_settings(8'h55, 8'h55, acfr_pkg::MOVE_CODE_RESET, acfr_pkg::MOVE_POSITION_RESET,
                  acfr_pkg::ANGLE_POSITION_RESET, acfr_pkg::SPEED_POSITION_RESET,
                  acfr_pkg::LIFETIME_MAX_RESET);
    send_word(acfr_pkg::OP_BYTE, LINK_A, 8'h55);
    send_word(acfr_pkg::OP_BYTE, LINK_A, "7");
    send_word(acfr_pkg::OP_BYTE, LINK_B, 8'h55);
    send_word(acfr_pkg::OP_BYTE, LINK_B, 8'hAA);
  endtask

  // shared position across links, restart while a frame is open
  task automatic test_shared_position();
    load_settings(CHR_START, CHR_STOP, acfr_pkg::MOVE_CODE_RESET,
                  acfr_pkg::MOVE_POSITION_RESET, acfr_pkg::ANGLE_POSITION_RESET,
                  acfr_pkg::SPEED_POSITION_RESET, acfr_pkg::LIFETIME_MAX_RESET);
    send_word(acfr_pkg::OP_BYTE, LINK_A, CHR_START);
    send_word(acfr_pkg::OP_BYTE, LINK_B, "9");
    send_word(acfr_pkg::OP_BYTE, LINK_A, CHR_STOP);
    send_word(acfr_pkg::OP_BYTE, LINK_B, CHR_START);
    send_word(acfr_pkg::OP_BYTE, LINK_A, CHR_START);
    send_word(acfr_pkg::OP_BYTE, LINK_B, CHR_STOP);
  endtask

  // mostly frames, with tick bursts and line noise
  task automatic test_random_traffic(input int unsigned count);
    int unsigned base;
    int unsigned pick;
    int unsigned k;
    randomise_settings();
    base = words_sent;
    while (words_sent - base < count) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_frame();
      end else if (pick < 85) begin
        k = $urandom_range(1, 12);
        repeat (k) send_word(acfr_pkg::OP_TICK, 1'($urandom_range(1)),
                             8'($urandom_range(255)));
      end else begin
        k = $urandom_range(1, 4);
        repeat (k) send_word(acfr_pkg::OP_BYTE, 1'($urandom_range(1)),
                             8'($urandom_range(255)));
      end
    end
    wait_quiet();
  endtask

  // receiver holds off for a long stretch while short frames keep coming
  task automatic test_stall_pressure();
    randomise_settings();
    hold_cycles = 300;
    repeat (30) begin
      send_word(acfr_pkg::OP_BYTE, 1'($urandom_range(1)), start_mk);
      send_word(acfr_pkg::OP_BYTE, 1'($urandom_range(1)), stop_mk);
    end
    wait_quiet();
  endtask

  initial begin
    foreach (link_buf[c, p]) link_buf[c][p] = 8'd0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    src_idle_pct  = 28;
    sink_idle_pct = 54;
    test_basic_frames();
    test_register_extremes();
    test_equal_markers();
    test_shared_position();
    test_random_traffic(300);

    src_idle_pct  = 54;
    sink_idle_pct = 28;
    test_random_traffic(300);

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    test_stall_pressure();
    test_random_traffic(300);

    wait_quiet();
    if (errors == 0) begin
      $display("ascii_command_frame_receiver: match");
    end else begin
      $display("ascii_command_frame_receiver: mismatch");
    end
    $finish;
  end

endmodule
